// ===== rtl/bpa_pkg.sv =====
// Shared constants, types and state codes of the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int MAX_PAGES   = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int OFF_W       = $clog2(MAX_PAGES) + 1;
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_AW    = $clog2(CHUNK_BITS);
    localparam int ADDR_W      = 20;
    localparam int COUNT_W     = 13;
    localparam int POOL_W      = 13;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_PAGES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_PAGE  = 1'b1;

    typedef enum logic [1:0] {
        REQ_INIT    = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_FREE    = 2'd2,
        REQ_RESERVE = 2'd3
    } t_req_type;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_INIT,
        S_SC_RD,
        S_SC_EV,
        S_SC_CHUNK,
        S_MK_RD,
        S_MK_WR,
        S_DONE
    } t_state;

    typedef logic [WORD_BITS-1:0] t_word;

endpackage

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap first-fit page allocator with its sequencer and datapath.
//
// One item is taken at a time and o_ready stays low until its result is queued in the
// output register. The used map sits in one RAM of 128 words of 32 bits and all work
// goes through its single read and write port. After reset the map is swept once to
// all free with o_ready low; configuration writes are accepted at any time. Init
// rewrites all 128 words. Alloc reads the map one word per cycle while words are fully
// free or fully used; a partly used word is searched 8 pages per cycle. A found run, a
// free or a reserve is then marked with a read and a write of each map word that the run
// touches. Results leave through one output register, and a new item is accepted while
// the previous result still waits.
`timescale 1ns / 1ps
module bitmap_page_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_page_number,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_page_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic [bpa_pkg::ADDR_W-1:0]      o_start_page
);

    import bpa_pkg::*;

    localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PAGES);
    localparam t_word            ALL_ONES = {WORD_BITS{1'b1}};

    t_state                r_state, n_state;
    logic [POOL_W-1:0]     r_pool, n_pool;
    logic [ADDR_W-1:0]     r_base, n_base;
    t_req_type             r_type, n_type;
    logic [ADDR_W-1:0]     r_page, n_page;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [OFF_W-1:0]      r_lim, n_lim;
    logic                  r_rep, n_rep;
    logic [OFF_W-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0]    r_run, n_run;
    logic [OFF_W-1:0]      r_first, n_first;
    t_word                 r_word, n_word;
    logic [OFF_W-1:0]      r_mlo, n_mlo;
    logic [OFF_W-1:0]      r_mend, n_mend;
    logic                  r_mset, n_mset;
    logic [WORD_AW-1:0]    r_midx, n_midx;
    logic                  r_found, n_found;
    logic                  r_out_valid, n_out_valid;
    logic                  r_status, n_status;
    logic [ADDR_W-1:0]     r_start, n_start;

    logic                  ram_wr_en;
    logic [WORD_AW-1:0]    ram_wr_addr;
    t_word                 ram_wr_data;
    logic                  ram_rd_en;
    logic [WORD_AW-1:0]    ram_rd_addr;
    t_word                 ram_rd_data;

    logic                  accept;
    logic [OFF_W-1:0]      acc_lim;

    logic [ADDR_W:0]       su_aend;
    logic [ADDR_W:0]       su_pend;
    logic [ADDR_W-1:0]     su_lo;
    logic [ADDR_W:0]       su_hi;
    logic                  su_empty;
    logic [OFF_W-1:0]      su_rel_lo;
    logic [OFF_W-1:0]      su_rel_end;

    logic                  ev_all_used;
    logic                  ev_all_free;
    logic [COUNT_W:0]      ev_sum;
    logic                  ev_hit;
    logic                  ev_mixed;
    logic [OFF_W-1:0]      pos_next_word;
    logic [OFF_W-1:0]      pos_next_chunk;
    logic                  word_end;
    logic                  chunk_last;
    logic                  chunk_end;

    logic [COUNT_W-1:0]    c_run;
    logic [OFF_W-1:0]      c_first;
    logic                  c_hit;

    logic [OFF_W-1:0]      in_wb;
    logic [OFF_W-1:0]      in_diff;
    t_word                 init_word;
    logic                  init_last;

    logic [OFF_W-1:0]      mk_last;
    logic [WORD_AW-1:0]    mk_last_widx;
    logic [BIT_AW-1:0]     mk_lo_off;
    logic [BIT_AW-1:0]     mk_hi_off;
    t_word                 mk_mask;
    t_word                 mk_word;
    logic                  mk_done;

    logic [OFF_W-1:0]      al_first;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign accept  = i_valid && o_ready;
    assign acc_lim = (32'(r_pool) > MAX_PAGES) ? MAX_OFF : OFF_W'(r_pool);

    // Clip a free or reserve run to the pool window.
    assign su_aend    = {1'b0, r_page} + (ADDR_W + 1)'(r_count);
    assign su_pend    = {1'b0, r_base} + (ADDR_W + 1)'(r_lim);
    assign su_lo      = (r_page > r_base) ? r_page : r_base;
    assign su_hi      = (su_aend < su_pend) ? su_aend : su_pend;
    assign su_empty   = (r_count == '0) || ((r_type == REQ_FREE) && (r_page == '0))
                        || (su_hi <= {1'b0, su_lo});
    assign su_rel_lo  = OFF_W'(su_lo - r_base);
    assign su_rel_end = OFF_W'(su_hi - {1'b0, r_base});

    assign ev_all_used    = &ram_rd_data;
    assign ev_all_free    = ~|ram_rd_data;
    assign ev_sum         = {1'b0, r_run} + (COUNT_W + 1)'(WORD_BITS);
    assign ev_hit         = ev_all_free && (ev_sum >= {1'b0, r_count});
    assign ev_mixed       = !ev_all_used && !ev_all_free;
    assign pos_next_word  = r_pos + OFF_W'(WORD_BITS);
    assign pos_next_chunk = r_pos + OFF_W'(CHUNK_BITS);
    assign word_end       = (pos_next_word == MAX_OFF);
    assign chunk_last     = &r_pos[BIT_AW-1:CHUNK_AW];
    assign chunk_end      = (pos_next_chunk == MAX_OFF);

    always_comb begin
        c_run   = r_run;
        c_first = r_first;
        c_hit   = 1'b0;
        for (int j = 0; j < CHUNK_BITS; j++) begin
            if (!c_hit) begin
                if (r_word[j]) begin
                    c_run   = '0;
                    c_first = r_pos + OFF_W'(j + 1);
                end else begin
                    c_run = c_run + 1'b1;
                    if (c_run == r_count) begin
                        c_hit = 1'b1;
                    end
                end
            end
        end
    end

    assign al_first = (r_state == S_SC_CHUNK) ? c_first : r_first;

    assign in_wb     = OFF_W'({r_midx, {BIT_AW{1'b0}}});
    assign in_diff   = r_lim - in_wb;
    assign init_last = (r_midx == WORD_AW'(WORD_COUNT - 1));
    always_comb begin
        if (r_lim <= in_wb) begin
            init_word = ALL_ONES;
        end else if (in_diff >= OFF_W'(WORD_BITS)) begin
            init_word = '0;
        end else begin
            init_word = ALL_ONES << in_diff[BIT_AW-1:0];
        end
    end

    assign mk_last      = r_mend - 1'b1;
    assign mk_last_widx = mk_last[BIT_AW+WORD_AW-1:BIT_AW];
    assign mk_lo_off    = (r_midx == r_mlo[BIT_AW+WORD_AW-1:BIT_AW]) ?
                          r_mlo[BIT_AW-1:0] : '0;
    assign mk_hi_off    = (r_midx == mk_last_widx) ? mk_last[BIT_AW-1:0] : '1;
    assign mk_mask      = (ALL_ONES << mk_lo_off)
                          & (ALL_ONES >> (BIT_AW'(WORD_BITS - 1) - mk_hi_off));
    assign mk_word      = r_mset ? (ram_rd_data | mk_mask) : (ram_rd_data & ~mk_mask);
    assign mk_done      = (r_midx == mk_last_widx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                unique case (r_type)
                    REQ_INIT:  n_state = S_INIT;
                    REQ_ALLOC: n_state = (r_count == '0) ? S_DONE : S_SC_RD;
                    default:   n_state = su_empty ? S_DONE : S_MK_RD;
                endcase
            end
            S_INIT: begin
                if (init_last) begin
                    n_state = r_rep ? S_DONE : S_IDLE;
                end
            end
            S_SC_RD: begin
                n_state = S_SC_EV;
            end
            S_SC_EV: begin
                if (ev_hit) begin
                    n_state = S_MK_RD;
                end else if (ev_mixed) begin
                    n_state = S_SC_CHUNK;
                end else if (word_end) begin
                    n_state = S_DONE;
                end
            end
            S_SC_CHUNK: begin
                if (c_hit) begin
                    n_state = S_MK_RD;
                end else if (chunk_last) begin
                    n_state = chunk_end ? S_DONE : S_SC_RD;
                end
            end
            S_MK_RD: begin
                n_state = S_MK_WR;
            end
            S_MK_WR: begin
                n_state = mk_done ? S_DONE : S_MK_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_midx;
        ram_wr_data = init_word;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_midx;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_INIT: begin
                ram_wr_en = 1'b1;
            end
            S_SC_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_pos[BIT_AW+WORD_AW-1:BIT_AW];
            end
            S_SC_EV: begin
                ram_rd_en   = !ev_hit && !ev_mixed && !word_end;
                ram_rd_addr = pos_next_word[BIT_AW+WORD_AW-1:BIT_AW];
            end
            S_MK_RD: begin
                ram_rd_en = 1'b1;
            end
            S_MK_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = mk_word;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_pool      = r_pool;
        n_base      = r_base;
        n_type      = r_type;
        n_page      = r_page;
        n_count     = r_count;
        n_lim       = r_lim;
        n_rep       = r_rep;
        n_pos       = r_pos;
        n_run       = r_run;
        n_first     = r_first;
        n_word      = r_word;
        n_mlo       = r_mlo;
        n_mend      = r_mend;
        n_mset      = r_mset;
        n_midx      = r_midx;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_start     = r_start;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POOL_PAGES: n_pool = i_cfg_data[POOL_W-1:0];
                CFG_BASE_PAGE:  n_base = i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_type  = t_req_type'(i_req_type);
                    n_page  = i_page_number;
                    n_count = i_page_count;
                    n_lim   = acc_lim;
                end
            end
            S_SETUP: begin
                n_rep   = 1'b1;
                n_midx  = '0;
                n_pos   = '0;
                n_run   = '0;
                n_first = '0;
                n_found = 1'b0;
                n_mlo   = su_rel_lo;
                n_mend  = su_rel_end;
                n_mset  = (r_type == REQ_RESERVE);
                if (r_type != REQ_INIT && r_type != REQ_ALLOC) begin
                    n_midx = su_rel_lo[BIT_AW+WORD_AW-1:BIT_AW];
                end
            end
            S_INIT: begin
                n_midx = r_midx + 1'b1;
            end
            S_SC_EV: begin
                n_word = ram_rd_data;
                if (ev_all_used) begin
                    n_run   = '0;
                    n_first = pos_next_word;
                    n_pos   = pos_next_word;
                end else if (ev_all_free && !ev_hit) begin
                    n_run = ev_sum[COUNT_W-1:0];
                    n_pos = pos_next_word;
                end
            end
            S_SC_CHUNK: begin
                n_run   = c_run;
                n_first = c_first;
                n_word  = r_word >> CHUNK_BITS;
                n_pos   = pos_next_chunk;
            end
            S_MK_WR: begin
                n_midx = r_midx + 1'b1;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_status    = (r_type == REQ_ALLOC) && !r_found;
                    n_start     = ((r_type == REQ_ALLOC) && r_found) ?
                                  r_base + ADDR_W'(r_mlo) : '0;
                end
            end
            default: begin
            end
        endcase

        if ((r_state == S_SC_EV && ev_hit) || (r_state == S_SC_CHUNK && c_hit)) begin
            n_found = 1'b1;
            n_mset  = 1'b1;
            n_mlo   = al_first;
            n_mend  = al_first + OFF_W'(r_count);
            n_midx  = al_first[BIT_AW+WORD_AW-1:BIT_AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pool      <= POOL_W'(MAX_PAGES);
            r_base      <= '0;
            r_lim       <= MAX_OFF;
            r_rep       <= 1'b0;
            r_midx      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool      <= n_pool;
            r_base      <= n_base;
            r_lim       <= n_lim;
            r_rep       <= n_rep;
            r_midx      <= n_midx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_type   <= n_type;
        r_page   <= n_page;
        r_count  <= n_count;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_first  <= n_first;
        r_word   <= n_word;
        r_mlo    <= n_mlo;
        r_mend   <= n_mend;
        r_mset   <= n_mset;
        r_status <= n_status;
        r_start  <= n_start;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_start_page = r_start;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("Allocator stayed ready after taking an item.");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_RD || r_state == S_SC_EV || r_state == S_SC_CHUNK) |-> !ram_wr_en)
        else $error("Map written during an alloc scan.");

    a_fail_has_null_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_start_page == '0))
        else $error("Failed alloc returned a nonzero start page.");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MK_WR) |-> (r_midx <= mk_last_widx && r_mend > r_mlo))
        else $error("Run marking walked past its last word.");

endmodule

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== test/bitmap_page_allocator_test.sv =====
// Self-checking testbench for the bitmap first-fit page allocator.
`timescale 1ns / 1ps
module bitmap_page_allocator_test;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int MAX_WAIT    = 16;

    typedef struct packed {
        t_req_type           kind;
        logic [ADDR_W-1:0]   page;
        logic [COUNT_W-1:0]  count;
    } t_page_req;

    typedef struct packed {
        logic                status;
        logic [ADDR_W-1:0]   start;
    } t_alloc_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_POOL_PAGES;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_req_type = REQ_INIT;
    logic [ADDR_W-1:0]      i_page_number = '0;
    logic [COUNT_W-1:0]     i_page_count = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_status;
    logic [ADDR_W-1:0]      o_start_page;

    bitmap_page_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .i_page_count  (i_page_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_start_page  (o_start_page)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the page map and of the two registers.
    bit                 used_map [MAX_PAGES];
    logic [POOL_W-1:0]  pool_reg = 13'd4096;
    logic [ADDR_W-1:0]  base_reg = '0;

    t_page_req      queued_reqs [$];
    t_alloc_outcome awaited_outcomes [$];
    t_page_req      next_req;

    int  error_count = 0;
    int  cycle_count = 0;
    int  req_total = 0;
    int  results_seen = 0;
    int  allocs_placed = 0;
    int  allocs_refused = 0;
    int  map_edits = 0;
    int  settings_used = 1;

    bit  req_taken = 1'b0;
    bit  rsp_taken = 1'b0;
    int  req_gap = 0;
    int  rsp_stall = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    function automatic int pool_span();
        return (pool_reg > MAX_PAGES) ? MAX_PAGES : int'(pool_reg);
    endfunction

    function automatic void clear_map();
        int span;
        span = pool_span();
        for (int p = 0; p < MAX_PAGES; p++) used_map[p] = (p >= span);
    endfunction

    // Pages below the base or past the end of the pool are left alone.
    function automatic void mark_run(logic [ADDR_W-1:0] first, logic [COUNT_W-1:0] count,
                                     bit used);
        logic [31:0] page;
        logic [31:0] offset;
        int          span;
        span = pool_span();
        for (int k = 0; k < count; k++) begin
            page = first + k;
            if (page < base_reg) continue;
            offset = page - base_reg;
            if (offset >= span) break;
            used_map[offset] = used;
        end
    endfunction

    function automatic t_alloc_outcome apply_request(t_page_req r);
        t_alloc_outcome res;
        int             run;
        int             first;
        logic [31:0]    sum;
        res.status = 1'b0;
        res.start  = '0;
        case (r.kind)
            REQ_INIT: begin
                clear_map();
            end
            REQ_ALLOC: begin
                res.status = 1'b1;
                if (r.count != 0) begin
                    run   = 0;
                    first = 0;
                    for (int p = 0; p < MAX_PAGES; p++) begin
                        if (used_map[p]) begin
                            run   = 0;
                            first = p + 1;
                        end else begin
                            run++;
                            if (run == r.count) begin
                                for (int k = 0; k < run; k++) used_map[first + k] = 1'b1;
                                res.status = 1'b0;
                                sum        = base_reg + first;
                                res.start  = sum[ADDR_W-1:0];
                                break;
                            end
                        end
                    end
                end
            end
            REQ_FREE: begin
                if (r.page != 0) mark_run(r.page, r.count, 1'b0);
            end
            default: begin
                mark_run(r.page, r.count, 1'b1);
            end
        endcase
        return res;
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void queue_req(t_req_type kind, int page, int count);
        t_page_req r;
        r.kind  = kind;
        r.page  = page[ADDR_W-1:0];
        r.count = count[COUNT_W-1:0];
        queued_reqs.push_back(r);
    endfunction

    // Mostly well-formed traffic inside the pool, with some requests anywhere at all.
    function automatic t_page_req random_request(int span, logic [ADDR_W-1:0] base);
        t_page_req r;
        int        pick;
        pick    = $urandom_range(0, 99);
        r.page  = ADDR_W'(base + $urandom_range(0, span));
        r.count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, MAX_PAGES))
                                              : COUNT_W'($urandom_range(1, 24));
        if (pick < 3) begin
            r.kind = REQ_INIT;
        end else if (pick < 50) begin
            r.kind = REQ_ALLOC;
        end else if (pick < 78) begin
            r.kind = REQ_FREE;
        end else if (pick < 92) begin
            r.kind = REQ_RESERVE;
        end else begin
            r.kind  = t_req_type'($urandom_range(0, 3));
            r.page  = ADDR_W'($urandom);
            r.count = COUNT_W'($urandom_range(0, MAX_PAGES));
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_POOL_PAGES) begin
            pool_reg = data[POOL_W-1:0];
        end else begin
            base_reg = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_pool(int pool);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[POOL_W-1:0] = pool[POOL_W-1:0];
        write_reg(CFG_POOL_PAGES, data);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (queued_reqs.size() != 0 || i_valid || awaited_outcomes.size() != 0);
    endtask

    // Request side.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (req_gap != 0) begin
                i_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (queued_reqs.size() != 0) begin
                next_req = queued_reqs.pop_front();
                i_valid       <= 1'b1;
                i_req_type    <= next_req.kind;
                i_page_number <= next_req.page;
                i_page_count  <= next_req.count;
                req_gap       <= draw_wait(tx_calm);
                if ($urandom_range(0, 31) == 0) tx_calm <= !tx_calm;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: a stall only runs down while a result is waiting.
    always @(negedge i_clk) begin : rx_side
        int stall;
        stall = rsp_taken ? draw_wait(rx_calm) : rsp_stall;
        if (rsp_taken && $urandom_range(0, 31) == 0) rx_calm <= !rx_calm;
        if (stall == 0) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b0;
            if (o_valid && !rsp_taken) stall = stall - 1;
        end
        rsp_stall <= stall;
    end

    always @(posedge i_clk) begin : watch
        t_alloc_outcome want;
        t_page_req      req;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && o_ready;
            rsp_taken <= o_valid && i_ready;
            if (o_valid && i_ready) begin
                results_seen++;
                if (awaited_outcomes.size() == 0) begin
                    note_error($sformatf("result with nothing outstanding: status %0d start 0x%05h",
                                         o_status, o_start_page));
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (o_status !== want.status)
                        note_error($sformatf("result %0d status: expected %0d, got %0d",
                                             results_seen, want.status, o_status));
                    if (o_start_page !== want.start)
                        note_error($sformatf("result %0d start_page: expected 0x%05h, got 0x%05h",
                                             results_seen, want.start, o_start_page));
                end
            end
            if (i_valid && o_ready) begin
                req.kind  = t_req_type'(i_req_type);
                req.page  = i_page_number;
                req.count = i_page_count;
                want = apply_request(req);
                awaited_outcomes.push_back(want);
                req_total++;
                if (req.kind == REQ_ALLOC) begin
                    if (want.status) allocs_refused++;
                    else allocs_placed++;
                end else if (req.kind != REQ_INIT) begin
                    map_edits++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int                pool;
        int                span;
        int                items;
        logic [ADDR_W-1:0] base;
        clear_map();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset map with the default pool: whole pool, full map, null free, zero counts.
        queue_req(REQ_ALLOC, 0, 4096);
        queue_req(REQ_ALLOC, 0, 1);
        queue_req(REQ_ALLOC, 0, 0);
        queue_req(REQ_FREE, 0, 10);
        queue_req(REQ_FREE, 1, 4096);
        queue_req(REQ_ALLOC, 0, 4096);
        queue_req(REQ_ALLOC, 0, 4095);
        queue_req(REQ_FREE, 100, 64);
        queue_req(REQ_RESERVE, 96, 0);
        queue_req(REQ_ALLOC, 0, 70);
        queue_req(REQ_ALLOC, 0, 64);
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_RESERVE, 32, 32);
        queue_req(REQ_ALLOC, 0, 40);
        wait_idle();

        // Oversized pool near the top of the page space: start pages wrap.
        set_pool(5000);
        write_reg(CFG_BASE_PAGE, 20'hFFFF0);
        settings_used++;
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_ALLOC, 0, 20);
        queue_req(REQ_ALLOC, 0, 20);
        queue_req(REQ_RESERVE, 20'hFFFFA, 100);
        queue_req(REQ_FREE, 5, 10);
        wait_idle();

        // Empty pool: everything is used.
        set_pool(0);
        write_reg(CFG_BASE_PAGE, 20'h12345);
        settings_used++;
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_ALLOC, 0, 1);
        queue_req(REQ_FREE, 20'h12345, 10);
        wait_idle();

        // Small pool: runs that start below the base are clipped.
        set_pool(40);
        write_reg(CFG_BASE_PAGE, 20'd100);
        settings_used++;
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_RESERVE, 90, 20);
        queue_req(REQ_ALLOC, 0, 31);
        queue_req(REQ_ALLOC, 0, 30);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            items = 135;
            case (ph)
                0: begin
                    pool = MAX_PAGES;
                    base = '0;
                end
                1: begin
                    pool = 1;
                    base = 20'hFFFFF;
                end
                2: begin
                    pool = $urandom_range(MAX_PAGES + 1, 8191);
                    base = ADDR_W'($urandom);
                end
                3: begin
                    pool  = 0;
                    base  = ADDR_W'($urandom);
                    items = 30;
                end
                4: begin
                    pool = MAX_PAGES;
                    base = ADDR_W'(20'hFFFFF - $urandom_range(0, MAX_PAGES - 1));
                end
                default: begin
                    pool = $urandom_range(0, 1) ? $urandom_range(1, MAX_PAGES)
                                                : $urandom_range(1, 300);
                    base = ADDR_W'($urandom);
                end
            endcase
            if ($urandom_range(0, 1)) begin
                set_pool(pool);
                write_reg(CFG_BASE_PAGE, base);
            end else begin
                write_reg(CFG_BASE_PAGE, base);
                set_pool(pool);
            end
            settings_used++;
            span = (pool > MAX_PAGES) ? MAX_PAGES : pool;
            if ($urandom_range(0, 9) != 0) queue_req(REQ_INIT, 0, 0);
            for (int n = 0; n < items; n++) queued_reqs.push_back(random_request(span, base));
            wait_idle();
        end

        repeat (300) @(posedge i_clk);
        $display("Ran %0d requests over %0d register settings in %0d cycles:", req_total,
                 settings_used, cycle_count);
        $display("%0d allocations placed, %0d refused, %0d frees and reserves.",
                 allocs_placed, allocs_refused, map_edits);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
